// ----- hdl/s2bt_pkg.sv -----
// Shared constants, control struct and fixed-point helper of the 2x2 solver.
package s2bt_pkg;

  localparam int unsigned FieldW     = 32;
  localparam int unsigned NumIn      = 6;
  localparam int unsigned OutW       = 32;
  localparam int unsigned FracBits   = 30;
  localparam int unsigned EpsW       = 31;
  localparam int unsigned CoefWDef   = 32;
  // quotient bits: two integer bits, the fraction and one rounding bit
  localparam int unsigned QuotW      = FracBits + 3;
  localparam int unsigned NumDivStep = QuotW;
  localparam logic [EpsW-1:0] EpsReset = EpsW'(1074);

  // field order inside the input word
  localparam int unsigned IdxA00 = 0;
  localparam int unsigned IdxA01 = 1;
  localparam int unsigned IdxB0  = 2;
  localparam int unsigned IdxA10 = 3;
  localparam int unsigned IdxA11 = 4;
  localparam int unsigned IdxB1  = 5;

  typedef struct packed {
    logic vld;
    logic sing;
    logic x_neg;
    logic y_neg;
    logic x_sat;
    logic y_sat;
  } s2bt_ctl_t;

  // round the quotient to Q2.30, apply sign and saturate to the output width
  function automatic logic signed [OutW-1:0] quot_to_fix(input logic [QuotW-1:0] q,
                                                         input logic sat,
                                                         input logic neg);
    logic [QuotW:0]   sum;
    logic [QuotW-1:0] mag;
    logic signed [OutW-1:0] res;
    sum = {1'b0, q} + (QuotW+1)'(1);
    mag = sat ? (QuotW'(1) << OutW) : sum[QuotW:1];
    if (mag == '0) begin
      res = '0;
    end else if (neg) begin
      if (mag >= (QuotW'(1) << (OutW-1))) res = {1'b1, {(OutW-1){1'b0}}};
      else res = -$signed(mag[OutW-1:0]);
    end else begin
      if (mag > QuotW'({1'b0, {(OutW-1){1'b1}}})) res = {1'b0, {(OutW-1){1'b1}}};
      else res = $signed(mag[OutW-1:0]);
    end
    return res;
  endfunction

endpackage

// ----- hdl/s2bt_det.sv -----
// Front pipeline: sign extension, six products, differences and magnitudes.
module s2bt_det #(
  parameter int unsigned COEF_W = s2bt_pkg::CoefWDef,
  parameter int unsigned PROD_W = 2 * s2bt_pkg::CoefWDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          vld_i,
  input  logic [s2bt_pkg::NumIn*s2bt_pkg::FieldW-1:0]   data_i,
  output s2bt_pkg::s2bt_ctl_t                           ctl_o,
  output logic [PROD_W-1:0]                             det_mag_o,
  output logic [PROD_W-1:0]                             nx_mag_o,
  output logic [PROD_W-1:0]                             ny_mag_o
);
  import s2bt_pkg::*;

  logic [FieldW-1:0]        fld    [NumIn];
  logic signed [COEF_W-1:0] coef_q [NumIn];
  logic signed [PROD_W-1:0] prod_q [6];
  logic signed [PROD_W:0]   diff_q [3];
  logic                     vld_a_q, vld_b_q, vld_c_q;
  s2bt_ctl_t                ctl_q;
  logic [PROD_W-1:0]        det_q, nx_q, ny_q;
  logic                     det_neg, nx_neg, ny_neg;

  for (genvar i = 0; i < NumIn; i++) begin : g_fld
    assign fld[i] = data_i[i*FieldW +: FieldW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      ctl_q   <= '0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      ctl_q   <= '{vld: vld_c_q, sing: (diff_q[0] == '0), x_neg: nx_neg ^ det_neg,
                   y_neg: ny_neg ^ det_neg, x_sat: 1'b0, y_sat: 1'b0};
    end
  end

  assign det_neg = diff_q[0][PROD_W];
  assign nx_neg  = diff_q[1][PROD_W];
  assign ny_neg  = diff_q[2][PROD_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NumIn; i++) coef_q[i] <= $signed(fld[i][COEF_W-1:0]);
      prod_q[0] <= coef_q[IdxA00] * coef_q[IdxA11];
      prod_q[1] <= coef_q[IdxA01] * coef_q[IdxA10];
      prod_q[2] <= coef_q[IdxB0]  * coef_q[IdxA11];
      prod_q[3] <= coef_q[IdxA01] * coef_q[IdxB1];
      prod_q[4] <= coef_q[IdxA00] * coef_q[IdxB1];
      prod_q[5] <= coef_q[IdxA10] * coef_q[IdxB0];
      for (int j = 0; j < 3; j++) begin
        diff_q[j] <= $signed({prod_q[2*j][PROD_W-1], prod_q[2*j]})
                   - $signed({prod_q[2*j+1][PROD_W-1], prod_q[2*j+1]});
      end
      // magnitudes reach at most 2^(PROD_W-1), so the top bit drops safely
      det_q <= det_neg ? PROD_W'(-diff_q[0]) : diff_q[0][PROD_W-1:0];
      nx_q  <= nx_neg  ? PROD_W'(-diff_q[1]) : diff_q[1][PROD_W-1:0];
      ny_q  <= ny_neg  ? PROD_W'(-diff_q[2]) : diff_q[2][PROD_W-1:0];
    end
  end

  assign ctl_o     = ctl_q;
  assign det_mag_o = det_q;
  assign nx_mag_o  = nx_q;
  assign ny_mag_o  = ny_q;

endmodule

// ----- hdl/s2bt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage for both unknowns.
module s2bt_div #(
  parameter int unsigned PROD_W = 2 * s2bt_pkg::CoefWDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  s2bt_pkg::s2bt_ctl_t           ctl_i,
  input  logic [PROD_W-1:0]             det_mag_i,
  input  logic [PROD_W-1:0]             nx_mag_i,
  input  logic [PROD_W-1:0]             ny_mag_i,
  output s2bt_pkg::s2bt_ctl_t           ctl_o,
  output logic [s2bt_pkg::QuotW-1:0]    qx_o,
  output logic [s2bt_pkg::QuotW-1:0]    qy_o
);
  import s2bt_pkg::*;

  localparam int unsigned RemW = PROD_W + 2;

  s2bt_ctl_t        ctl_q [NumDivStep+1];
  logic [RemW-1:0]  d4_q  [NumDivStep+1];
  logic [RemW-1:0]  rx_q  [NumDivStep+1];
  logic [RemW-1:0]  ry_q  [NumDivStep+1];
  logic [QuotW-1:0] qx_q  [NumDivStep+1];
  logic [QuotW-1:0] qy_q  [NumDivStep+1];
  logic [RemW-1:0]  d4;
  logic             sat_x, sat_y;
  s2bt_ctl_t        ctl_d;

  // divide by 4*det so the two integer bits fall out of the same recurrence
  assign d4    = {det_mag_i, 2'b00};
  assign sat_x = {2'b00, nx_mag_i} >= {det_mag_i, 2'b00};
  assign sat_y = {2'b00, ny_mag_i} >= {det_mag_i, 2'b00};

  always_comb begin
    ctl_d       = ctl_i;
    ctl_d.x_sat = sat_x;
    ctl_d.y_sat = sat_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d4_q[0] <= d4;
      rx_q[0] <= sat_x ? '0 : {2'b00, nx_mag_i};
      ry_q[0] <= sat_y ? '0 : {2'b00, ny_mag_i};
      qx_q[0] <= '0;
      qy_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < NumDivStep; k++) begin : g_step
    logic [RemW:0] rx2, ry2, dd;
    logic          gex, gey;

    assign dd  = {1'b0, d4_q[k]};
    assign rx2 = {rx_q[k], 1'b0};
    assign ry2 = {ry_q[k], 1'b0};
    assign gex = rx2 >= dd;
    assign gey = ry2 >= dd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d4_q[k+1] <= d4_q[k];
        rx_q[k+1] <= gex ? RemW'(rx2 - dd) : rx2[RemW-1:0];
        ry_q[k+1] <= gey ? RemW'(ry2 - dd) : ry2[RemW-1:0];
        qx_q[k+1] <= {qx_q[k][QuotW-2:0], gex};
        qy_q[k+1] <= {qy_q[k][QuotW-2:0], gey};
      end
    end
  end

  assign ctl_o = ctl_q[NumDivStep];
  assign qx_o  = qx_q[NumDivStep];
  assign qy_o  = qy_q[NumDivStep];

endmodule

// ----- hdl/s2bt_test.sv -----
// Rounding, saturation and the barycentric inside test; holds the output register.
module s2bt_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  s2bt_pkg::s2bt_ctl_t           ctl_i,
  input  logic [s2bt_pkg::QuotW-1:0]    qx_i,
  input  logic [s2bt_pkg::QuotW-1:0]    qy_i,
  input  logic [s2bt_pkg::EpsW-1:0]     eps_i,
  output logic                          vld_o,
  output logic                          hit_o,
  output logic [s2bt_pkg::OutW-1:0]     sol_x_o,
  output logic [s2bt_pkg::OutW-1:0]     sol_y_o
);
  import s2bt_pkg::*;

  s2bt_ctl_t              ctl_f_q;
  logic signed [OutW-1:0] x_f_q, y_f_q;
  logic                   vld_q, hit_q;
  logic [OutW-1:0]        x_q, y_q;
  logic signed [OutW:0]   x_e, y_e, neg_eps;
  logic signed [OutW+1:0] sum_xy, lim;
  logic                   hit_d;

  assign x_e     = {x_f_q[OutW-1], x_f_q};
  assign y_e     = {y_f_q[OutW-1], y_f_q};
  assign neg_eps = -$signed({{(OutW+1-EpsW){1'b0}}, eps_i});
  assign sum_xy  = {x_e[OutW], x_e} + {y_e[OutW], y_e};
  assign lim     = $signed({{(OutW+2-EpsW){1'b0}}, eps_i}) + ((OutW+2)'(1) <<< FracBits);
  assign hit_d   = !ctl_f_q.sing && (x_e >= neg_eps) && (y_e >= neg_eps) && (sum_xy <= lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_f_q <= '0;
      vld_q   <= 1'b0;
    end else if (en_i) begin
      ctl_f_q <= ctl_i;
      vld_q   <= ctl_f_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_f_q <= quot_to_fix(qx_i, ctl_i.x_sat, ctl_i.x_neg);
      y_f_q <= quot_to_fix(qy_i, ctl_i.y_sat, ctl_i.y_neg);
      hit_q <= hit_d;
      x_q   <= hit_d ? x_f_q : '0;
      y_q   <= hit_d ? y_f_q : '0;
    end
  end

  assign vld_o   = vld_q;
  assign hit_o   = hit_q;
  assign sol_x_o = x_q;
  assign sol_y_o = y_q;

  a_sing_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && ctl_f_q.vld && ctl_f_q.sing) |=> (vld_q && !hit_q))
    else $error("singular system reported as hit");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q))
    else $error("output valid moved during a stall");

  a_vld_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (vld_q == $past(ctl_f_q.vld)))
    else $error("valid bit lost on advance");

endmodule

// ----- hdl/solve_2x2_barycentric_test.sv -----
// Top level of the pipelined 2x2 linear solver with barycentric inside test.
//
//  channel  | direction | signals            | word
//  ---------+-----------+--------------------+-----------------------------------
//  s_axis   | in        | tvalid/tready/tdata| six Q16.16 coefficients
//  m_axis   | out       | tvalid/tready/tdata| Q2.30 solution, tuser = hit
//  cfg      | in        | valid/ready/data   | epsilon, unsigned Q1.30
//
// One word per cycle enters unless m_axis stalls. Stages: 4 front (extend,
// multiply, subtract, magnitude), 34 divider (setup plus one quotient bit per
// stage), rounding, and the inside test that feeds the output register.
// Reset clears every valid bit and loads epsilon with its default.
// A stall at m_axis freezes the whole pipeline in place; s_axis_tready drops
// only while the output register holds an untaken word.
module solve_2x2_barycentric_test #(
  parameter int unsigned COEF_WIDTH = s2bt_pkg::CoefWDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // eq_a_x_coef, eq_a_y_coef, eq_a_rhs, eq_b_x_coef, eq_b_y_coef, eq_b_rhs
  input  logic [s2bt_pkg::NumIn*s2bt_pkg::FieldW-1:0]  s_axis_tdata_i,
  output logic                                         m_axis_tvalid_o,
  input  logic                                         m_axis_tready_i,
  // sol_x, sol_y
  output logic [2*s2bt_pkg::OutW-1:0]                  m_axis_tdata_o,
  // hit
  output logic                                         m_axis_tuser_o,
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  logic [s2bt_pkg::EpsW-1:0]                    cfg_data_i
);
  import s2bt_pkg::*;

  localparam int unsigned CoefW = (COEF_WIDTH > FieldW) ? FieldW : COEF_WIDTH;
  localparam int unsigned ProdW = 2 * CoefW;

  logic             en;
  logic [EpsW-1:0]  eps_q;
  s2bt_ctl_t        det_ctl, div_ctl;
  logic [ProdW-1:0] det_mag, nx_mag, ny_mag;
  logic [QuotW-1:0] qx, qy;
  logic             out_vld, hit;
  logic [OutW-1:0]  sol_x, sol_y;

  // advance everything unless a finished word waits downstream
  assign en              = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  s2bt_det #(
    .COEF_W (CoefW),
    .PROD_W (ProdW)
  ) u_det (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (s_axis_tvalid_i),
    .data_i    (s_axis_tdata_i),
    .ctl_o     (det_ctl),
    .det_mag_o (det_mag),
    .nx_mag_o  (nx_mag),
    .ny_mag_o  (ny_mag)
  );

  s2bt_div #(
    .PROD_W (ProdW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (det_ctl),
    .det_mag_i (det_mag),
    .nx_mag_i  (nx_mag),
    .ny_mag_i  (ny_mag),
    .ctl_o     (div_ctl),
    .qx_o      (qx),
    .qy_o      (qy)
  );

  s2bt_test u_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (div_ctl),
    .qx_i    (qx),
    .qy_i    (qy),
    .eps_i   (eps_q),
    .vld_o   (out_vld),
    .hit_o   (hit),
    .sol_x_o (sol_x),
    .sol_y_o (sol_y)
  );

  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tuser_o  = hit;
  assign m_axis_tdata_o  = {sol_y, sol_x};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (eps_q == $past(cfg_data_i)))
    else $error("epsilon write lost");

  a_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld && !hit) |-> (sol_x == '0 && sol_y == '0))
    else $error("miss carries a nonzero solution");

endmodule

// ----- verif/tb_solve_2x2_barycentric_test.sv -----
// Self-checking testbench of the 2x2 solver with barycentric inside test.
module tb_solve_2x2_barycentric_test;
  import s2bt_pkg::*;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned DrainWait  = 60;
  localparam int unsigned LongHold   = 400;
  localparam logic [31:0] QOne       = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] b1;
    logic signed [31:0] a11;
    logic signed [31:0] a10;
    logic signed [31:0] b0;
    logic signed [31:0] a01;
    logic signed [31:0] a00;
  } system_t;

  typedef struct {
    logic        hit;
    logic [31:0] sol_x;
    logic [31:0] sol_y;
  } solution_t;

  // Exact rational solve, rounding and inside test for the accepted systems.
  class solution_board;
    solution_t   pending_q[$];
    logic [30:0] eps_q30;
    int          errors;
    int          n_hit;
    int          n_sing;
    int          n_checked;

    function new();
      eps_q30 = EpsReset;
    endfunction

    // n / d rounded to Q2.30, ties away from zero, saturated to 32 bits
    function automatic longint quot_q30(logic signed [65:0] n, logic signed [65:0] d);
      logic [65:0] nm, dm, q, rem, mag;
      logic neg;
      nm  = n[65] ? -n : n;
      dm  = d[65] ? -d : d;
      neg = n[65] != d[65];
      q   = nm / dm;
      rem = nm % dm;
      if (q >= 4) begin
        mag = 66'd1 << 32;
      end else begin
        for (int i = 0; i < FracBits + 1; i++) begin
          rem = rem << 1;
          q   = q << 1;
          if (rem >= dm) begin
            rem  = rem - dm;
            q[0] = 1'b1;
          end
        end
        mag = (q + 1) >> 1;
      end
      if (mag == 0) return 0;
      if (neg) begin
        if (mag >= (66'd1 << 31)) return -(longint'(1) << 31);
        return -longint'(mag);
      end
      if (mag > 66'h7FFF_FFFF) return longint'(32'h7FFF_FFFF);
      return longint'(mag);
    endfunction

    function void note_system(system_t s);
      logic signed [65:0] a00, a01, b0, a10, a11, b1, det, nx, ny;
      longint x, y, eps;
      solution_t r;
      a00 = s.a00; a01 = s.a01; b0 = s.b0;
      a10 = s.a10; a11 = s.a11; b1 = s.b1;
      r   = '{1'b0, 32'd0, 32'd0};
      eps = longint'(eps_q30);
      det = a00 * a11 - a01 * a10;
      if (det == 0) begin
        n_sing++;
      end else begin
        nx = b0 * a11 - a01 * b1;
        ny = a00 * b1 - a10 * b0;
        x  = quot_q30(nx, det);
        y  = quot_q30(ny, det);
        if (!(x < -eps || y < -eps || x + y > (longint'(1) << FracBits) + eps)) begin
          r = '{1'b1, x[31:0], y[31:0]};
          n_hit++;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %0s: got %h want %h (word %0d)", what, got, want, n_checked);
    endfunction

    function void check_word(logic hit, logic [31:0] sx, logic [31:0] sy);
      solution_t w;
      if (pending_q.size() == 0) begin
        report("unexpected word", {31'd0, hit}, 32'd0);
        return;
      end
      w = pending_q.pop_front();
      if (hit !== w.hit)     report("hit", {31'd0, hit}, {31'd0, w.hit});
      if (sx !== w.sol_x)    report("sol_x", sx, w.sol_x);
      if (sy !== w.sol_y)    report("sol_y", sy, w.sol_y);
      n_checked++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [191:0] s_axis_tdata_i = '0;  // eq_a_x_coef, eq_a_y_coef, eq_a_rhs, eq_b_x_coef,
                                      // eq_b_y_coef, eq_b_rhs
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // sol_x, sol_y
  logic        m_axis_tuser_o;        // hit
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [30:0] cfg_data_i = '0;

  solution_board sb = new();
  int  idle_cycles = 0;
  bit  hold_req = 0;
  int  rx_mode = 0;
  bit  no_gaps = 0;

  solve_2x2_barycentric_test u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // count cycles with no word moving anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("timeout: no handshake for %0d cycles", WatchLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: check each taken word, then pick the next ready or hold it low
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        sb.check_word(m_axis_tuser_o, m_axis_tdata_o[31:0], m_axis_tdata_o[63:32]);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        case (rx_mode)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic send_system(system_t s);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_system(s);
  endtask

  task automatic write_eps(logic [30:0] eps);
    // drain the pipe before touching the tolerance
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= eps;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.eps_q30 = eps;
  endtask

  function automatic system_t mk(logic [31:0] a00, logic [31:0] a01, logic [31:0] b0,
                                 logic [31:0] a10, logic [31:0] a11, logic [31:0] b1);
    return '{b1, a11, a10, b0, a01, a00};
  endfunction

  // system whose solution lands near or inside the unit triangle
  function automatic system_t well_formed();
    longint a[4], x, y;
    int span;
    span = $urandom_range(4, 24);
    foreach (a[i]) begin
      a[i] = longint'($urandom_range(0, (1 << span) - 1)) - (longint'(1) << (span - 1));
      if ($urandom_range(0, 9) == 0) a[i] = 0;
    end
    x = $urandom_range(0, 1 << 30);
    y = $urandom_range(0, (1 << 30) - int'(x));
    if ($urandom_range(0, 3) == 0) x = x - $urandom_range(0, 4096);
    if ($urandom_range(0, 3) == 0) y = y + $urandom_range(0, 4096);
    return mk(32'(a[0]), 32'(a[1]), 32'((a[0] * x + a[1] * y) >>> 30),
              32'(a[2]), 32'(a[3]), 32'((a[2] * x + a[3] * y) >>> 30));
  endfunction

  function automatic system_t singular();
    logic signed [31:0] a00, a01, k;
    a00 = $signed($urandom_range(0, 65535)) - 32768;
    a01 = $signed($urandom_range(0, 65535)) - 32768;
    k   = $signed($urandom_range(0, 15)) - 8;
    return mk(a00, a01, $urandom, a00 * k, a01 * k, $urandom);
  endfunction

  function automatic system_t any_system();
    system_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) s = well_formed();
    else if (pick < 75) s = singular();
    else s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    return s;
  endfunction

  task automatic run_random(int count);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_system(any_system());
        sent++;
      end
      gap = no_gaps ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7));
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  initial begin
    system_t directed[$];
    directed = '{
      mk(0, 0, 0, 0, 0, 0),
      mk(QOne, 0, 32'h4000, 0, QOne, 32'h4000),
      mk(QOne, 0, QOne, 0, QOne, 0),
      mk(QOne, 0, 32'h8001, 0, QOne, 32'h8000),
      mk(QOne, 0, -QOne, 0, QOne, 32'h8000),
      mk(0, QOne, 32'h4CCC, QOne, 0, 32'h3333),
      mk(2 * QOne, 0, 32'h8000, QOne, QOne, 32'hC000),
      mk(QOne, QOne, 32'h8000, 0, QOne, 32'h4000),
      mk(QOne, QOne, 32'hC000, QOne, 0, 32'h4000),
      mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF),
      mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000),
      mk(32'h8000_0000, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
      mk(1, 0, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000),
      mk(QOne, 0, -1, 0, QOne, 32'h4000),
      mk(QOne, 2 * QOne, QOne, 2 * QOne, 4 * QOne, 5 * QOne),
      mk(3, 0, 1, 0, 3, 1),
      mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF),
      mk(-QOne, 0, -32'h4000, 0, -QOne, -32'h2000)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tolerance first, all stimulus back to back
    foreach (directed[i]) send_system(directed[i]);
    s_axis_tvalid_i <= 1'b0;

    rx_mode = 1;
    run_random(250);

    write_eps(31'd0);
    foreach (directed[i]) send_system(directed[i]);
    rx_mode = 2;
    run_random(300);

    write_eps(31'h4000_0000);
    rx_mode = 0;
    no_gaps = 1;
    hold_req = 1;   // fill the pipe against a stalled output
    run_random(300);
    no_gaps = 0;

    write_eps(31'($urandom_range(0, 1 << 20)));
    rx_mode = 1;
    run_random(300);

    write_eps(31'd1074);
    rx_mode = 2;
    run_random(300);

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.pending_q.size() != 0) sb.report("words missing", sb.pending_q.size(), 0);

    $display("checked %0d words: %0d inside hits, %0d singular systems", sb.n_checked,
             sb.n_hit, sb.n_sing);
    $display("tolerance settings 1074, 0, 1.0 and random; one long output stall");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
